// ===== sv/sbq_pkg.sv =====
// Shared constants and coefficient register index codes for the stereo biquad filter.
`default_nettype none

package sbq_pkg;

  localparam int NUM_COEFS = 5;
  localparam int COEF_IDX_W = 3;

  typedef enum logic [COEF_IDX_W-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_t;

endpackage

`default_nettype wire

// ===== sv/sbq_coef_regs.sv =====
// Coefficient register file written through the configuration port.
`default_nettype none

module sbq_coef_regs #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [sbq_pkg::COEF_IDX_W-1:0]        cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                 cfg_data,
  output logic signed [COEF_WIDTH-1:0]               b0,
  output logic signed [COEF_WIDTH-1:0]               b1,
  output logic signed [COEF_WIDTH-1:0]               b2,
  output logic signed [COEF_WIDTH-1:0]               a1,
  output logic signed [COEF_WIDTH-1:0]               a2
);

  localparam logic signed [COEF_WIDTH-1:0] UNITY =
    {2'b01, {(COEF_WIDTH-2){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= UNITY;
      b1 <= '0;
      b2 <= '0;
      a1 <= '0;
      a2 <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbq_pkg::IDX_B0: b0 <= cfg_data;
        sbq_pkg::IDX_B1: b1 <= cfg_data;
        sbq_pkg::IDX_B2: b2 <= cfg_data;
        sbq_pkg::IDX_A1: a1 <= cfg_data;
        sbq_pkg::IDX_A2: a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbq_chan.sv =====
// One channel of the direct form I biquad: history registers and the sum of products.
`default_nettype none

module sbq_chan #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              update,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    x,
  input  wire logic signed [COEF_WIDTH-1:0]      b0,
  input  wire logic signed [COEF_WIDTH-1:0]      b1,
  input  wire logic signed [COEF_WIDTH-1:0]      b2,
  input  wire logic signed [COEF_WIDTH-1:0]      a1,
  input  wire logic signed [COEF_WIDTH-1:0]      a2,
  output logic signed [SAMPLE_WIDTH-1:0]         y
);

  localparam int PW   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int AW   = PW + 3;
  localparam int FRAC = COEF_WIDTH - 2;

  localparam logic signed [AW-1:0] RND_HALF = {{(AW-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic signed [AW-1:0] SAT_HI =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO =
    {{(AW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic signed [SAMPLE_WIDTH-1:0] x2;
  logic signed [SAMPLE_WIDTH-1:0] y1;
  logic signed [SAMPLE_WIDTH-1:0] y2;

  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [PW-1:0] p3;
  logic signed [PW-1:0] p4;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] scaled;

  always_comb begin
    p0 = x  * b0;
    p1 = x1 * b1;
    p2 = x2 * b2;
    p3 = y1 * a1;
    p4 = y2 * a2;
    acc = AW'(p0) + AW'(p1) + AW'(p2) - AW'(p3) - AW'(p4) + RND_HALF;
    scaled = acc >>> FRAC;
    if (scaled > SAT_HI) begin
      y = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (scaled < SAT_LO) begin
      y = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y = scaled[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (update) begin
      x1 <= x;
      x2 <= x1;
      y1 <= y;
      y2 <= y1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stereo_biquad_iir_filter.sv =====
// Top level of the stereo direct form I biquad filter.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   left_in, right_in
//   output    out_valid / out_stall left_out, right_out
//   config    cfg_wr_en             cfg_index, cfg_data
//
// One frame is accepted per cycle while in_stall is low; its result is loaded into the output
// register when the input register advances, and is offered from there.
// The throughput is set by the feedback through y1, which closes inside each channel's
// multiply and add.
// Reset clears the coefficients to unity gain, the history and the valid flags of both pipeline stages.
// A stalled output holds its result; the input register keeps accepting until it is full.
`default_nettype none

module stereo_biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    left_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    right_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         left_out,
  output logic signed [SAMPLE_WIDTH-1:0]         right_out,
  input  wire logic                              cfg_wr_en,
  input  wire logic [sbq_pkg::COEF_IDX_W-1:0]    cfg_index,
  input  wire logic [COEF_WIDTH-1:0]             cfg_data
);

  logic signed [COEF_WIDTH-1:0] b0;
  logic signed [COEF_WIDTH-1:0] b1;
  logic signed [COEF_WIDTH-1:0] b2;
  logic signed [COEF_WIDTH-1:0] a1;
  logic signed [COEF_WIDTH-1:0] a2;

  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_left;
  logic signed [SAMPLE_WIDTH-1:0] s1_right;
  logic signed [SAMPLE_WIDTH-1:0] left_y;
  logic signed [SAMPLE_WIDTH-1:0] right_y;

  logic s2_load;
  logic s1_adv;
  logic in_xfer;

  assign s2_load  = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && s2_load;
  assign in_stall = s1_valid && !s2_load;
  assign in_xfer  = in_valid && !in_stall;

  sbq_coef_regs #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .b0        (b0),
    .b1        (b1),
    .b2        (b2),
    .a1        (a1),
    .a2        (a2)
  );

  sbq_chan #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_left (
    .clk    (clk),
    .rst    (rst),
    .update (s1_adv),
    .x      (s1_left),
    .b0     (b0),
    .b1     (b1),
    .b2     (b2),
    .a1     (a1),
    .a2     (a2),
    .y      (left_y)
  );

  sbq_chan #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_right (
    .clk    (clk),
    .rst    (rst),
    .update (s1_adv),
    .x      (s1_right),
    .b0     (b0),
    .b1     (b1),
    .b2     (b2),
    .a1     (a1),
    .a2     (a2),
    .y      (right_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_left  <= left_in;
      s1_right <= right_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_out  <= left_y;
      right_out <= right_y;
    end
  end

  a_in_lands : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted frame did not reach the input register");

  a_s1_moves : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !(out_valid && out_stall) |=> out_valid)
    else $error("input register advanced but no result appeared");

  a_no_extra : assert property (@(posedge clk) disable iff (rst)
    !s1_valid && out_valid && !out_stall |=> !out_valid)
    else $error("result repeated after its transfer");

  a_reset_clear : assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
